// ----- design/byte_pattern_scanner_assert.svh -----
// ----------------------------------------------------------------------------
// byte_pattern_scanner assertion macros
// Short forms for the concurrent checks of the scanner, clocked on clk and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SCANNER_ASSERT_SVH
`define BYTE_PATTERN_SCANNER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define BPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, register indexes and helpers of the byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bps_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int ADDR_W              = 64;
  localparam int OFFSET_W            = 32;
  localparam int LENGTH_W            = 5;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_RESULT_OFF   = 3'd3,
    REG_START_ADDR   = 3'd4
  } cfg_reg_t;

  // Pattern byte k; bytes past the two 64-bit registers read as zero.
  function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                              input logic [63:0] hi,
                                              input int          k);
    logic [7:0] b;
    b = 8'h00;
    if (k >= 0 && k < 8) begin
      b = lo[8*k +: 8];
    end else if (k >= 8 && k < 16) begin
      b = hi[8*(k-8) +: 8];
    end
    return b;
  endfunction

endpackage

// ----- design/byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// byte_pattern_scanner
// Searches a byte stream for a configured pattern of up to PATTERN_MAX bytes
// and reports the first match address of each scan, or a miss at its end.
// ----------------------------------------------------------------------------
// One byte is taken every cycle with no bubbles while results are drained; a
// result (found with the match start address plus the signed offset, or a miss
// with address zero on the last byte) appears in the output register in the cycle
// after the byte that completes it. While a result waits untaken, s_tready is
// low and the input stalls until the transaction on the result side completes.
// The per-byte path is the window compare against a pre-aligned pattern plus
// a 64-bit add and subtract for the address; start_address + result_offset
// and the aligned pattern are folded into registers when the configuration is
// written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "byte_pattern_scanner_assert.svh"

module byte_pattern_scanner
  import bps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // byte stream in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  // result out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [ADDR_W-1:0]      m_tdata,   // [63:0] match_address
  output logic                   m_tuser    // found
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int WD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  // configuration
  logic [63:0]         pat_lo, pat_hi;
  logic [LENGTH_W-1:0] pat_len;
  logic [OFFSET_W-1:0] res_off;
  logic [ADDR_W-1:0]   start_addr;
  logic [ADDR_W-1:0]   base;          // start_addr + sign-extended res_off
  logic [LW-1:0]       len_eff;
  logic [LW-1:0]       len_m1;
  logic [7:0]          align  [PATTERN_MAX];
  logic                mask   [PATTERN_MAX];

  logic [63:0]         pat_lo_next, pat_hi_next;
  logic [LENGTH_W-1:0] pat_len_next;
  logic [OFFSET_W-1:0] res_off_next;
  logic [ADDR_W-1:0]   start_addr_next;
  logic [LW-1:0]       len_eff_next;
  logic [7:0]          align_next [PATTERN_MAX];
  logic                mask_next  [PATTERN_MAX];
  logic                cfg_wr;

  // scan state
  logic [7:0]        win  [WD];
  logic [7:0]        view [PATTERN_MAX];
  logic [ADDR_W-1:0] seen;
  logic [ADDR_W-1:0] seen_inc;
  logic              done;
  logic              in_acc;
  logic              enough;
  logic              hit;
  logic              match;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    pat_lo_next     = pat_lo;
    pat_hi_next     = pat_hi;
    pat_len_next    = pat_len;
    res_off_next    = res_off;
    start_addr_next = start_addr;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pat_lo_next     = cfg_data;
        REG_PATTERN_HIGH: pat_hi_next     = cfg_data;
        REG_PATTERN_LEN:  pat_len_next    = cfg_data[LENGTH_W-1:0];
        REG_RESULT_OFF:   res_off_next    = cfg_data[OFFSET_W-1:0];
        REG_START_ADDR:   start_addr_next = cfg_data;
        default: ;
      endcase
    end
    // zero acts as one, oversize clamps to the window size
    if (pat_len_next == '0) begin
      len_eff_next = LW'(1);
    end else if (int'(pat_len_next) > PATTERN_MAX) begin
      len_eff_next = LW'(PATTERN_MAX);
    end else begin
      len_eff_next = LW'(pat_len_next);
    end
    // view slot j (newest first) must hold pattern byte len-1-j
    for (int j = 0; j < PATTERN_MAX; j++) begin
      mask_next[j]  = (j < int'(len_eff_next));
      align_next[j] = mask_next[j] ?
        pattern_byte(pat_lo_next, pat_hi_next, int'(len_eff_next) - 1 - j) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo     <= '0;
      pat_hi     <= '0;
      pat_len    <= LENGTH_W'(1);
      res_off    <= '0;
      start_addr <= '0;
      base       <= '0;
      len_eff    <= LW'(1);
      len_m1     <= '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        align[j] <= 8'h00;
        mask[j]  <= (j == 0);
      end
    end else if (cfg_wr) begin
      pat_lo     <= pat_lo_next;
      pat_hi     <= pat_hi_next;
      pat_len    <= pat_len_next;
      res_off    <= res_off_next;
      start_addr <= start_addr_next;
      base       <= start_addr_next + {{(ADDR_W-OFFSET_W){res_off_next[OFFSET_W-1]}},
                                       res_off_next};
      len_eff    <= len_eff_next;
      len_m1     <= len_eff_next - LW'(1);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        align[j] <= align_next[j];
        mask[j]  <= mask_next[j];
      end
    end
  end

  // datapath
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign seen_inc = seen + ADDR_W'(1);

  always_comb begin
    view[0] = s_tdata;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      view[i] = win[i-1];
    end
    hit = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (mask[j] && (view[j] != align[j])) begin
        hit = 1'b0;
      end
    end
    enough = (seen_inc[ADDR_W-1:LW] != '0) || (seen_inc[LW-1:0] >= len_eff);
    match  = enough && hit;
  end

  always_ff @(posedge clk) begin
    if (in_acc && !done) begin
      for (int i = 0; i < WD; i++) begin
        win[i] <= view[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      done     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_acc) begin
        if (!done) begin
          seen <= seen_inc;
          if (match) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b1;
            m_tdata  <= base + seen - ADDR_W'(len_m1);
            done     <= 1'b1;
          end else if (s_tlast) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b0;
            m_tdata  <= '0;
          end
        end
        if (s_tlast) begin
          seen <= '0;
          done <= 1'b0;
        end
      end
    end
  end

  `BPS_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready,
                   "input stalled with an empty output register")
  `BPS_ASSERT_SAME(a_miss_zero_addr, m_tvalid && !m_tuser, m_tdata == '0,
                   "miss result with nonzero address")
  `BPS_ASSERT_NEXT(a_quiet_after_match, in_acc && done && !m_tvalid, !m_tvalid,
                   "result produced after the scan already matched")
  `BPS_ASSERT_NEXT(a_match_sets_done, in_acc && !done && match && !s_tlast,
                   done && m_tvalid && m_tuser, "match did not close the scan")
  `BPS_ASSERT_NEXT(a_rearm_on_last, in_acc && s_tlast, (seen == '0) && !done,
                   "scanner did not rearm after the last byte")

endmodule
